// File: rtl/rhc_pkg.sv
// shared types and constants of the rgb / hsv pixel converter
package rhc_pkg;

    // mode codes
    localparam logic MODE_TO_HSV = 1'b0;
    localparam logic MODE_TO_RGB = 1'b1;

    localparam int unsigned HUE_TURN     = 1536;
    localparam int unsigned SECTOR_STEPS = 256;
    localparam int unsigned FULL_SCALE   = 255;
    localparam int unsigned WEIGHT_FULL  = FULL_SCALE * SECTOR_STEPS;

    // hue sector base offsets in steps
    localparam int unsigned BASE_RED   = HUE_TURN;
    localparam int unsigned BASE_GREEN = 2 * SECTOR_STEPS;
    localparam int unsigned BASE_BLUE  = 4 * SECTOR_STEPS;

    // quotient widths and bits resolved per divider stage
    localparam int unsigned HUE_QW    = 11;
    localparam int unsigned SAT_QW    = 8;
    localparam int unsigned BITS_STEP = 2;
    localparam int unsigned DIV_STAGES = (HUE_QW + BITS_STEP - 1) / BITS_STEP;

    // entry stage plus divider stages, output register comes after
    localparam int unsigned PIPE_STAGES = DIV_STAGES + 1;

    // hue sectors
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic        mode;
        logic        zero;      // max equals min
        logic [7:0]  lvl;
        logic [7:0]  dlt;
        logic [7:0]  mx;
        logic [18:0] hrem;
        logic [10:0] hq;
        logic [15:0] srem;
        logic [7:0]  sq;
        logic [7:0]  v;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        logic [23:0] nr;
        logic [23:0] ng;
        logic [23:0] nb;
        logic [7:0]  cr;
        logic [7:0]  cg;
        logic [7:0]  cb;
    } stage_t;

endpackage

// File: rtl/rgb_hsv_color_converter_top.sv
// Converts a pixel between 8-bit RGB and HSV (1536 hue steps) in a pipeline that takes one
// request per clock. It has one entry stage (max, min, hue numerator; sector weights times
// saturation), six divider stages that resolve two quotient bits each of the hue division
// (one bit in the last) and of the saturation division (first four only), and the output
// register. The hsv to rgb path uses the first two divider stages for its value multiply
// and its division by 255. Every stage holds while the one after it is full and stalled,
// so in_ready falls only when the whole pipeline is full and out_ready is low.
module rgb_hsv_color_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [10:0] in_hue,
    input  logic [7:0]  in_sat,
    input  logic [7:0]  in_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [10:0] out_hue,
    output logic [7:0]  out_sat,
    output logic [7:0]  out_level
);

    localparam int unsigned NS = rhc_pkg::PIPE_STAGES;

    rhc_pkg::stage_t            pipe_reg  [NS];
    rhc_pkg::stage_t            pipe_next [NS];
    rhc_pkg::stage_t            entry_next;
    logic [NS-1:0]              valid_reg;
    logic [NS:0]                adv;

    logic [7:0]  out_red_reg,   out_red_next;
    logic [7:0]  out_green_reg, out_green_next;
    logic [7:0]  out_blue_reg,  out_blue_next;
    logic [10:0] out_hue_reg,   out_hue_next;
    logic [7:0]  out_sat_reg,   out_sat_next;
    logic [7:0]  out_level_reg, out_level_next;
    logic        out_valid_reg;

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[NS] = !out_valid_reg || out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    // entry stage
    always_comb
    begin
        rhc_pkg::stage_t st;
        logic [7:0]  mx_rg;
        logic [7:0]  mn_rg;
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  dlt;
        logic [7:0]  pos_ch;
        logic [7:0]  neg_ch;
        logic [10:0] base;
        logic [19:0] num;
        logic [10:0] hw;
        logic [8:0]  up;
        logic [8:0]  dn;
        logic [8:0]  xr;
        logic [8:0]  xg;
        logic [8:0]  xb;

        st = '0;
        mx_rg = (in_red > in_green) ? in_red : in_green;
        mn_rg = (in_red < in_green) ? in_red : in_green;
        mx = (mx_rg > in_blue) ? mx_rg : in_blue;
        mn = (mn_rg < in_blue) ? mn_rg : in_blue;
        dlt = mx - mn;

        if (mx == in_red)
        begin
            base   = 11'(rhc_pkg::BASE_RED);
            pos_ch = in_green;
            neg_ch = in_blue;
        end
        else if (mx == in_green)
        begin
            base   = 11'(rhc_pkg::BASE_GREEN);
            pos_ch = in_blue;
            neg_ch = in_red;
        end
        else
        begin
            base   = 11'(rhc_pkg::BASE_BLUE);
            pos_ch = in_red;
            neg_ch = in_green;
        end
        // never negative and below 2^19 once summed
        num = 20'(base) * 20'(dlt) + {4'd0, pos_ch, 8'd0} - {4'd0, neg_ch, 8'd0};

        st.mode = mode;
        st.zero = (dlt == 8'd0);
        st.lvl  = mx;
        st.dlt  = dlt;
        st.mx   = mx;
        st.hrem = num[18:0];
        st.hq   = '0;
        st.srem = 16'(16'(dlt) * 16'(rhc_pkg::FULL_SCALE));
        st.sq   = '0;

        // hsv to rgb: weight of each channel, then saturation times its complement
        hw = (in_hue >= 11'(rhc_pkg::HUE_TURN)) ? in_hue - 11'(rhc_pkg::HUE_TURN) : in_hue;
        up = {1'b0, hw[7:0]};
        dn = 9'(rhc_pkg::SECTOR_STEPS) - up;
        unique case (rhc_pkg::sector_t'(hw[10:8]))
            rhc_pkg::SECT_RY:
            begin
                xr = 9'(rhc_pkg::SECTOR_STEPS); xg = up; xb = '0;
            end
            rhc_pkg::SECT_YG:
            begin
                xr = dn; xg = 9'(rhc_pkg::SECTOR_STEPS); xb = '0;
            end
            rhc_pkg::SECT_GC:
            begin
                xr = '0; xg = 9'(rhc_pkg::SECTOR_STEPS); xb = up;
            end
            rhc_pkg::SECT_CB:
            begin
                xr = '0; xg = dn; xb = 9'(rhc_pkg::SECTOR_STEPS);
            end
            rhc_pkg::SECT_BM:
            begin
                xr = up; xg = '0; xb = 9'(rhc_pkg::SECTOR_STEPS);
            end
            default:
            begin
                xr = 9'(rhc_pkg::SECTOR_STEPS); xg = '0; xb = dn;
            end
        endcase
        st.v  = in_level;
        st.pr = 16'(16'(in_sat) * 16'(9'(rhc_pkg::SECTOR_STEPS) - xr));
        st.pg = 16'(16'(in_sat) * 16'(9'(rhc_pkg::SECTOR_STEPS) - xg));
        st.pb = 16'(16'(in_sat) * 16'(9'(rhc_pkg::SECTOR_STEPS) - xb));

        entry_next = st;
    end

    // divider stages, up to two quotient bits each; rgb multiply and scaling ride along
    always_comb
    begin
        rhc_pkg::stage_t st;
        int          bh;
        int          bs;
        logic [18:0] trial_h;
        logic [15:0] trial_s;
        logic [16:0] sr;
        logic [16:0] sg;
        logic [16:0] sb;

        bh      = 0;
        bs      = 0;
        trial_h = '0;
        trial_s = '0;
        sr      = '0;
        sg      = '0;
        sb      = '0;
        pipe_next[0] = entry_next;
        for (int k = 1; k < NS; k++)
        begin
            st = pipe_reg[k-1];
            for (int j = 0; j < rhc_pkg::BITS_STEP; j++)
            begin
                bh = rhc_pkg::HUE_QW - 1 - rhc_pkg::BITS_STEP * (k - 1) - j;
                bs = rhc_pkg::SAT_QW - 1 - rhc_pkg::BITS_STEP * (k - 1) - j;
                if (bh >= 0)
                begin
                    trial_h = 19'(st.dlt) << bh;
                    if (st.hrem >= trial_h)
                    begin
                        st.hrem  = st.hrem - trial_h;
                        st.hq[bh] = 1'b1;
                    end
                end
                if (bs >= 0)
                begin
                    trial_s = 16'(st.mx) << bs;
                    if (st.srem >= trial_s)
                    begin
                        st.srem  = st.srem - trial_s;
                        st.sq[bs] = 1'b1;
                    end
                end
            end
            if (k == 1)
            begin
                st.nr = 24'(st.v) * 24'(16'(rhc_pkg::WEIGHT_FULL) - st.pr);
                st.ng = 24'(st.v) * 24'(16'(rhc_pkg::WEIGHT_FULL) - st.pg);
                st.nb = 24'(st.v) * 24'(16'(rhc_pkg::WEIGHT_FULL) - st.pb);
            end
            if (k == 2)
            begin
                // floor(n / 65280): drop 8 bits, then divide by 255 via reciprocal
                sr = 17'(st.nr[23:8]) + 17'(st.nr[23:16]) + 17'd1;
                sg = 17'(st.ng[23:8]) + 17'(st.ng[23:16]) + 17'd1;
                sb = 17'(st.nb[23:8]) + 17'(st.nb[23:16]) + 17'd1;
                st.cr = sr[15:8];
                st.cg = sg[15:8];
                st.cb = sb[15:8];
            end
            pipe_next[k] = st;
        end
    end

    // output selection
    always_comb
    begin
        rhc_pkg::stage_t st;
        logic [10:0] hwrap;

        st = pipe_reg[NS-1];
        hwrap = (st.hq >= 11'(rhc_pkg::HUE_TURN)) ? st.hq - 11'(rhc_pkg::HUE_TURN) : st.hq;
        if (st.mode == rhc_pkg::MODE_TO_RGB)
        begin
            out_red_next   = st.cr;
            out_green_next = st.cg;
            out_blue_next  = st.cb;
            out_hue_next   = '0;
            out_sat_next   = '0;
            out_level_next = '0;
        end
        else
        begin
            out_red_next   = '0;
            out_green_next = '0;
            out_blue_next  = '0;
            out_hue_next   = st.zero ? '0 : hwrap;
            out_sat_next   = st.zero ? '0 : st.sq;
            out_level_next = st.lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (adv[NS])
            begin
                out_valid_reg <= valid_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (adv[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (adv[NS])
        begin
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
            out_hue_reg   <= out_hue_next;
            out_sat_reg   <= out_sat_next;
            out_level_reg <= out_level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_hue   = out_hue_reg;
    assign out_sat   = out_sat_reg;
    assign out_level = out_level_reg;

`ifndef SYNTH
    // with the sink taking results, no stage can block a new request
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled while output is drained");

    // hue is always folded into one turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_hue < 11'(rhc_pkg::HUE_TURN)))
        else $error("hue out of range");

    // only one mode's fields carry data
    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_hue == '0 && out_sat == '0 && out_level == '0) ||
                       (out_red == '0 && out_green == '0 && out_blue == '0)))
        else $error("both result groups non-zero");

    // a stalled last stage keeps its request until the output frees up
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-1] && !adv[NS]) |=> valid_reg[NS-1])
        else $error("request lost in last stage");
`endif

endmodule
